### rtl/ccs_pkg.sv
`timescale 1ns / 1ps
package ccs_pkg;

	localparam int COORD_W = 19;
	localparam int IDX_W   = 10;
	localparam int MAG_W   = 18;
	localparam int DEN_W   = 19;

	typedef logic [1:0] sign_t;
	localparam sign_t SG_NEG  = 2'd0;
	localparam sign_t SG_ZERO = 2'd1;
	localparam sign_t SG_POS  = 2'd2;

	// segment kinds per triangle (a, b corners, c centre, X = crossing)
	typedef logic [3:0] seg_case_t;
	localparam seg_case_t CASE_NONE    = 4'd0;
	localparam seg_case_t CASE_AC      = 4'd1;
	localparam seg_case_t CASE_CB      = 4'd2;
	localparam seg_case_t CASE_BA      = 4'd3;
	localparam seg_case_t CASE_A_XCB   = 4'd4;
	localparam seg_case_t CASE_C_XBA   = 4'd5;
	localparam seg_case_t CASE_B_XCB   = 4'd6;
	localparam seg_case_t CASE_XAC_XCB = 4'd7;
	localparam seg_case_t CASE_XCB_XBA = 4'd8;
	localparam seg_case_t CASE_XBA_XAC = 4'd9;

	localparam seg_case_t CASE_TABLE [0:31] = '{
		CASE_NONE, CASE_NONE, CASE_XCB_XBA,
		CASE_NONE, CASE_CB, CASE_C_XBA,
		CASE_XAC_XCB, CASE_B_XCB, CASE_XBA_XAC,
		CASE_NONE, CASE_BA, CASE_A_XCB,
		CASE_AC, CASE_BA, CASE_AC,
		CASE_A_XCB, CASE_BA, CASE_NONE,
		CASE_XBA_XAC, CASE_B_XCB, CASE_XAC_XCB,
		CASE_C_XBA, CASE_CB, CASE_NONE,
		CASE_XCB_XBA, CASE_NONE, CASE_NONE,
		CASE_NONE, CASE_NONE, CASE_NONE, CASE_NONE, CASE_NONE
	};

	typedef struct packed {
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] row;
		seg_case_t [3:0]  cases;
	} cell_side_t;

	typedef struct packed {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
	} seg_t;

	function automatic seg_case_t case_of(sign_t sa, sign_t sc, sign_t sb);
		logic [4:0] idx;
		idx = 5'(sa) * 5'd9 + 5'(sc) * 5'd3 + 5'(sb);
		return CASE_TABLE[idx];
	endfunction

endpackage

### rtl/contour_cell_segments_core.sv
`timescale 1ns / 1ps
// Contour segments of one grid cell for one level. A transaction is taken when start is
// high and busy is low; busy then stays high while the spacing counter runs down, so
// that the output side, giving out at most one segment per cycle, has given out all
// segments of a cell before those of the next reach it. A cell passes s1, s2, s3, the
// crossing dividers (one quotient bit per stage, most of the path), s4, s5 and the
// output register; the segments of a cell follow on consecutive cycles, each on
// result_strobe for exactly one cycle, with last_segment on the final one. The receiver
// cannot hold results off. A level outside the cell's range gives no strobe at all.
module contour_cell_segments_core #(
	parameter int GRID_WIDTH    = 1024,
	parameter int GRID_HEIGHT   = 1024,
	parameter int FRACTION_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [9:0]         cell_column,
	input  logic [9:0]         cell_row,
	input  logic signed [15:0] corner_a,
	input  logic signed [15:0] corner_b,
	input  logic signed [15:0] corner_c,
	input  logic signed [15:0] corner_d,
	input  logic signed [15:0] level,
	output logic               result_strobe,
	output logic [18:0]        start_x,
	output logic [18:0]        start_y,
	output logic [18:0]        end_x,
	output logic [18:0]        end_y,
	output logic               last_segment
);
	localparam int F       = FRACTION_BITS;
	localparam int QW      = F + 1;
	localparam int YW      = QW + 1;
	localparam int OW      = F + 2;
	localparam int CW      = (F + 12 > 19) ? F + 12 : 19;
	localparam int COL_MAX = GRID_WIDTH - 2;
	localparam int ROW_MAX = GRID_HEIGHT - 2;
	localparam int IW      = ccs_pkg::IDX_W;
	localparam int MW      = ccs_pkg::MAG_W;
	localparam int DW      = ccs_pkg::DEN_W;
	localparam logic [CW-1:0] HALF = CW'(1) << (F - 1);

	function automatic ccs_pkg::sign_t sign_from(logic neg, logic zero);
		if (zero)
			return ccs_pkg::SG_ZERO;
		else if (neg)
			return ccs_pkg::SG_NEG;
		else
			return ccs_pkg::SG_POS;
	endfunction

	// rounded offset from the corner: half selects a half-cell span, neg a negative span
	function automatic logic signed [OW-1:0] cross_off(logic [QW-1:0] q, logic nz,
			logic half, logic neg);
		logic [QW-1:0] qq;
		logic          nzz;
		logic [YW-1:0] y;
		qq  = half ? (q >> 1) : q;
		nzz = half ? (nz | q[0]) : nz;
		if (neg) begin
			y = YW'(qq) + YW'(nzz);
			return -$signed(OW'(y >> 1));
		end else begin
			y = YW'(qq) + YW'(1);
			return $signed(OW'(y >> 1));
		end
	endfunction

	// issue spacing
	logic [1:0] gap_q;
	logic       accept;

	assign busy   = gap_q != 2'd0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
		end else if (accept) begin
			gap_q <= 2'd3;
		end else if (gap_q != 2'd0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// s1: clamp, corner minus level
	logic                    v_s1;
	logic [IW-1:0]           col_s1, row_s1;
	logic signed [16:0]      d_s1 [4];
	logic signed [15:0]      smp  [4];

	assign smp[0] = corner_a;
	assign smp[1] = corner_b;
	assign smp[2] = corner_c;
	assign smp[3] = corner_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= (int'(cell_column) > COL_MAX) ? IW'(COL_MAX) : cell_column;
		row_s1 <= (int'(cell_row) > ROW_MAX) ? IW'(ROW_MAX) : cell_row;
		for (int m = 0; m < 4; m++)
			d_s1[m] <= 17'(smp[m]) - 17'(level);
	end

	// s2: centre sum, magnitudes
	logic                    v_s2;
	logic [IW-1:0]           col_s2, row_s2;
	logic signed [16:0]      d_s2 [4];
	logic [15:0]             absd_s2 [4];
	logic signed [18:0]      h0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		col_s2 <= col_s1;
		row_s2 <= row_s1;
		h0_s2  <= (19'(d_s1[0]) + 19'(d_s1[1])) + (19'(d_s1[2]) + 19'(d_s1[3]));
		for (int m = 0; m < 4; m++) begin
			d_s2[m]    <= d_s1[m];
			absd_s2[m] <= d_s1[m][16] ? 16'(-d_s1[m]) : 16'(d_s1[m]);
		end
	end

	// s3: case selection and divider operands
	// edges 0..3: corner to centre; 4..7: corner to next corner
	ccs_pkg::sign_t     sg [4];
	ccs_pkg::sign_t     sgc;
	logic               reject;
	logic [MW-1:0]      mag [4];
	logic [MW-1:0]      absh0;
	logic               vld_s [0:QW];
	ccs_pkg::cell_side_t side_s [0:QW];
	logic [MW-1:0]      num_s3 [8];
	logic [DW-1:0]      den_s3 [8];

	always_comb begin
		logic any_pos, any_neg, touch;
		any_pos = 1'b0;
		any_neg = 1'b0;
		touch   = 1'b0;
		for (int m = 0; m < 4; m++) begin
			sg[m]  = sign_from(d_s2[m][16], d_s2[m] == 17'sd0);
			mag[m] = {absd_s2[m], 2'b00};
			any_pos |= !d_s2[m][16] && d_s2[m] != 17'sd0;
			any_neg |= d_s2[m][16];
			touch   |= d_s2[m] == 17'sd0;
		end
		sgc    = sign_from(h0_s2[18], h0_s2 == 19'sd0);
		absh0  = h0_s2[18] ? MW'(-h0_s2) : MW'(h0_s2);
		reject = (!any_neg || !any_pos) && !touch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++)
				vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= v_s2;
			for (int k = 0; k < QW; k++)
				vld_s[k+1] <= vld_s[k];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0].col <= col_s2;
		side_s[0].row <= row_s2;
		for (int m = 0; m < 4; m++) begin
			side_s[0].cases[m] <= reject ? ccs_pkg::CASE_NONE :
				ccs_pkg::case_of(sg[m], sgc, sg[(m + 1) % 4]);
			num_s3[m]     <= mag[m];
			den_s3[m]     <= DW'(mag[m]) + DW'(absh0);
			num_s3[m + 4] <= mag[m];
			den_s3[m + 4] <= DW'(mag[m]) + DW'(mag[(m + 1) % 4]);
		end
		for (int k = 0; k < QW; k++)
			side_s[k+1] <= side_s[k];
	end

	logic [QW-1:0] quo [8];
	logic          nz  [8];

	for (genvar e = 0; e < 8; e++) begin : g_edge
		ccs_div #(.STEPS(QW)) u_div (
			.clk    (clk),
			.num    (num_s3[e]),
			.den    (den_s3[e]),
			.quo    (quo[e]),
			.rem_nz (nz[e])
		);
	end

	// s4: points. 0 centre, 1..4 corners, 5..8 centre crossings, 9..12 side crossings
	logic                        v_s4;
	ccs_pkg::seg_case_t [3:0]    cases_s4;
	logic [CW-1:0]               px_s4 [13];
	logic [CW-1:0]               py_s4 [13];
	logic [CW-1:0]               px [13];
	logic [CW-1:0]               py [13];

	always_comb begin
		logic [CW-1:0] cx, cy;
		logic          dxb, dyb;
		cx = CW'(side_s[QW].col);
		cy = CW'(side_s[QW].row);
		px[0] = (cx + CW'(1)) << F;
		py[0] = (cy + CW'(1)) << F;
		for (int k = 0; k < 4; k++) begin
			dxb = (k == 1) || (k == 2);
			dyb = (k >= 2);
			px[1 + k] = ((cx + CW'(dxb)) << F) + HALF;
			py[1 + k] = ((cy + CW'(dyb)) << F) + HALF;
			px[5 + k] = px[1 + k] + CW'(cross_off(quo[k], nz[k], 1'b1, dxb));
			py[5 + k] = py[1 + k] + CW'(cross_off(quo[k], nz[k], 1'b1, dyb));
			px[9 + k] = px[1 + k];
			py[9 + k] = py[1 + k];
			if (k == 0 || k == 2)
				px[9 + k] = px[1 + k] + CW'(cross_off(quo[4 + k], nz[4 + k], 1'b0, k == 2));
			else
				py[9 + k] = py[1 + k] + CW'(cross_off(quo[4 + k], nz[4 + k], 1'b0, k == 3));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		cases_s4 <= side_s[QW].cases;
		px_s4    <= px;
		py_s4    <= py;
	end

	// s5: segment per triangle
	logic [3:0]      mask_s5;
	ccs_pkg::seg_t   seg_s5 [4];
	logic [3:0]      mask_n;
	ccs_pkg::seg_t   seg_n [4];

	always_comb begin
		int a, b;
		for (int t = 0; t < 4; t++) begin
			a = t;
			b = (t + 1) % 4;
			mask_n[t] = v_s4;
			seg_n[t]  = '0;
			unique case (cases_s4[t])
				ccs_pkg::CASE_AC: begin
					seg_n[t] = {px_s4[1 + a][18:0], py_s4[1 + a][18:0],
						px_s4[0][18:0], py_s4[0][18:0]};
				end
				ccs_pkg::CASE_CB: begin
					seg_n[t] = {px_s4[0][18:0], py_s4[0][18:0],
						px_s4[1 + b][18:0], py_s4[1 + b][18:0]};
				end
				ccs_pkg::CASE_BA: begin
					seg_n[t] = {px_s4[1 + b][18:0], py_s4[1 + b][18:0],
						px_s4[1 + a][18:0], py_s4[1 + a][18:0]};
				end
				ccs_pkg::CASE_A_XCB: begin
					seg_n[t] = {px_s4[1 + a][18:0], py_s4[1 + a][18:0],
						px_s4[5 + b][18:0], py_s4[5 + b][18:0]};
				end
				ccs_pkg::CASE_C_XBA: begin
					seg_n[t] = {px_s4[0][18:0], py_s4[0][18:0],
						px_s4[9 + t][18:0], py_s4[9 + t][18:0]};
				end
				ccs_pkg::CASE_B_XCB: begin
					seg_n[t] = {px_s4[1 + b][18:0], py_s4[1 + b][18:0],
						px_s4[5 + b][18:0], py_s4[5 + b][18:0]};
				end
				ccs_pkg::CASE_XAC_XCB: begin
					seg_n[t] = {px_s4[5 + a][18:0], py_s4[5 + a][18:0],
						px_s4[5 + b][18:0], py_s4[5 + b][18:0]};
				end
				ccs_pkg::CASE_XCB_XBA: begin
					seg_n[t] = {px_s4[5 + b][18:0], py_s4[5 + b][18:0],
						px_s4[9 + t][18:0], py_s4[9 + t][18:0]};
				end
				ccs_pkg::CASE_XBA_XAC: begin
					seg_n[t] = {px_s4[9 + t][18:0], py_s4[9 + t][18:0],
						px_s4[5 + a][18:0], py_s4[5 + a][18:0]};
				end
				default: begin
					mask_n[t] = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s5 <= 4'd0;
		end else begin
			mask_s5 <= mask_n;
		end
	end

	always_ff @(posedge clk) begin
		seg_s5 <= seg_n;
	end

	// output: first segment straight from s5, the rest from the hold buffer
	logic [3:0]      pend_q;
	ccs_pkg::seg_t   hold_q [4];
	logic [3:0]      src_mask, rest;
	ccs_pkg::seg_t   src_seg [4];
	logic [1:0]      sel;
	logic            strobe_q, last_q;
	ccs_pkg::seg_t   out_q;

	always_comb begin
		src_mask = (mask_s5 != 4'd0) ? mask_s5 : pend_q;
		src_seg  = (mask_s5 != 4'd0) ? seg_s5 : hold_q;
		sel      = 2'd0;
		priority if (src_mask[0])
			sel = 2'd0;
		else if (src_mask[1])
			sel = 2'd1;
		else if (src_mask[2])
			sel = 2'd2;
		else
			sel = 2'd3;
		rest = src_mask & ~(4'd1 << sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 4'd0;
			strobe_q <= 1'b0;
		end else begin
			pend_q   <= rest;
			strobe_q <= src_mask != 4'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (mask_s5 != 4'd0)
			hold_q <= seg_s5;
		out_q  <= src_seg[sel];
		last_q <= rest == 4'd0;
	end

	assign result_strobe = strobe_q;
	assign start_x       = out_q.sx;
	assign start_y       = out_q.sy;
	assign end_x         = out_q.ex;
	assign end_y         = out_q.ey;
	assign last_segment  = last_q;

endmodule

### rtl/ccs_div.sv
`timescale 1ns / 1ps
// restoring fraction divider, one quotient bit per stage, num < den
module ccs_div #(
	parameter int STEPS = 9
) (
	input  logic                       clk,
	input  logic [ccs_pkg::MAG_W-1:0]  num,
	input  logic [ccs_pkg::DEN_W-1:0]  den,
	output logic [STEPS-1:0]           quo,
	output logic                       rem_nz
);
	localparam int RW = ccs_pkg::DEN_W + 1;

	logic [RW-1:0]               rem_s [0:STEPS];
	logic [ccs_pkg::DEN_W-1:0]   den_s [0:STEPS];
	logic [STEPS-1:0]            quo_s [0:STEPS];

	assign rem_s[0] = RW'(num);
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [RW:0] dbl;
		logic        ge;
		assign dbl = {rem_s[k], 1'b0};
		assign ge  = dbl >= (RW + 1)'(den_s[k]);
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? RW'(dbl - (RW + 1)'(den_s[k])) : RW'(dbl);
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= {quo_s[k][STEPS-2:0], ge};
		end
	end

	assign quo    = quo_s[STEPS];
	assign rem_nz = rem_s[STEPS] != '0;

endmodule

### rtl/ccs_checker.sv
`timescale 1ns / 1ps
module ccs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_strobe,
	input logic last_segment
);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a transaction");

	a_busy_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		busy && $past(busy, 1) && $past(busy, 2) |=> !busy)
		else $error("busy held beyond three cycles");

	a_cell_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_segment |=> result_strobe)
		else $error("segments of a cell not contiguous");

endmodule

bind contour_cell_segments_core ccs_checker u_ccs_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int GRID_W   = 1024;
	localparam int GRID_H   = 1024;
	localparam int FRAC     = 8;
	localparam int LATENCY  = FRAC + 6;
	localparam int N_RANDOM = 290;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic [18:0] sx;
		logic [18:0] sy;
		logic [18:0] ex;
		logic [18:0] ey;
		logic        last;
	} segment_t;

	class segment_scoreboard;
		segment_t pending[$];
		int       errors;
		int       cells;
		int       segments;

		static function longint cross_at(longint hp, longint hq, longint xp, longint xq);
			longint num;
			longint den;
			num = hq * xp - hp * xq;
			den = hq - hp;
			if (den == 0)
				return xp;
			if (den < 0) begin
				num = -num;
				den = -den;
			end
			if (num < 0)
				num = 0;
			return (num + den / 2) / den;
		endfunction

		function void note_cell(logic [9:0] ci, logic [9:0] rj, logic signed [15:0] ca,
				logic signed [15:0] cb, logic signed [15:0] cc, logic signed [15:0] cd,
				logic signed [15:0] lv);
			longint h[5];
			longint xs[5];
			longint ys[5];
			int sg[5];
			int tbl[27];
			longint col;
			longint row;
			longint d;
			longint x1;
			longint y1;
			longint x2;
			longint y2;
			bit pos;
			bit neg;
			bit touch;
			int n;
			int a;
			int b;
			int k;
			logic signed [15:0] corner[4];
			tbl = '{0, 0, 8, 0, 2, 5, 7, 6, 9, 0, 3, 4, 1, 3, 1, 4, 3, 0,
				9, 6, 7, 5, 2, 0, 8, 0, 0};
			corner = '{ca, cb, cc, cd};
			col = (ci > GRID_W - 2) ? GRID_W - 2 : ci;
			row = (rj > GRID_H - 2) ? GRID_H - 2 : rj;
			cells++;
			h[0] = 0;
			pos = 0;
			neg = 0;
			touch = 0;
			for (int m = 1; m <= 4; m++) begin
				d = longint'(corner[m-1]) - longint'(lv);
				h[m] = d * 4;
				h[0] += d;
				xs[m] = ((col + ((m == 2 || m == 3) ? 1 : 0)) << FRAC) + (1 << (FRAC - 1));
				ys[m] = ((row + ((m >= 3) ? 1 : 0)) << FRAC) + (1 << (FRAC - 1));
				if (d > 0) pos = 1;
				if (d < 0) neg = 1;
				if (d == 0) touch = 1;
			end
			xs[0] = (col + 1) << FRAC;
			ys[0] = (row + 1) << FRAC;
			if ((!pos || !neg) && !touch)
				return;
			for (int m = 0; m < 5; m++)
				sg[m] = h[m] > 0 ? 1 : (h[m] < 0 ? -1 : 0);
			n = 0;
			for (int m = 1; m <= 4; m++) begin
				segment_t s;
				a = m;
				b = (m == 4) ? 1 : m + 1;
				k = tbl[(sg[a] + 1) * 9 + (sg[0] + 1) * 3 + sg[b] + 1];
				case (k)
					1: begin x1 = xs[a]; y1 = ys[a]; x2 = xs[0]; y2 = ys[0]; end
					2: begin x1 = xs[0]; y1 = ys[0]; x2 = xs[b]; y2 = ys[b]; end
					3: begin x1 = xs[b]; y1 = ys[b]; x2 = xs[a]; y2 = ys[a]; end
					4: begin
						x1 = xs[a]; y1 = ys[a];
						x2 = cross_at(h[0], h[b], xs[0], xs[b]);
						y2 = cross_at(h[0], h[b], ys[0], ys[b]);
					end
					5: begin
						x1 = xs[0]; y1 = ys[0];
						x2 = cross_at(h[b], h[a], xs[b], xs[a]);
						y2 = cross_at(h[b], h[a], ys[b], ys[a]);
					end
					6: begin
						x1 = xs[b]; y1 = ys[b];
						x2 = cross_at(h[b], h[0], xs[b], xs[0]);
						y2 = cross_at(h[b], h[0], ys[b], ys[0]);
					end
					7: begin
						x1 = cross_at(h[a], h[0], xs[a], xs[0]);
						y1 = cross_at(h[a], h[0], ys[a], ys[0]);
						x2 = cross_at(h[0], h[b], xs[0], xs[b]);
						y2 = cross_at(h[0], h[b], ys[0], ys[b]);
					end
					8: begin
						x1 = cross_at(h[0], h[b], xs[0], xs[b]);
						y1 = cross_at(h[0], h[b], ys[0], ys[b]);
						x2 = cross_at(h[b], h[a], xs[b], xs[a]);
						y2 = cross_at(h[b], h[a], ys[b], ys[a]);
					end
					9: begin
						x1 = cross_at(h[b], h[a], xs[b], xs[a]);
						y1 = cross_at(h[b], h[a], ys[b], ys[a]);
						x2 = cross_at(h[a], h[0], xs[a], xs[0]);
						y2 = cross_at(h[a], h[0], ys[a], ys[0]);
					end
					default: continue;
				endcase
				s.sx = x1[18:0];
				s.sy = y1[18:0];
				s.ex = x2[18:0];
				s.ey = y2[18:0];
				s.last = 0;
				pending.push_back(s);
				n++;
			end
			if (n > 0)
				pending[$].last = 1;
		endfunction

		function void check_segment(logic [18:0] sx, logic [18:0] sy, logic [18:0] ex,
				logic [18:0] ey, logic last);
			segment_t e;
			segments++;
			if (pending.size() == 0) begin
				$error("unexpected segment %0d,%0d -> %0d,%0d", sx, sy, ex, ey);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (sx !== e.sx) begin $error("start_x exp %0d got %0d", e.sx, sx); errors++; end
			if (sy !== e.sy) begin $error("start_y exp %0d got %0d", e.sy, sy); errors++; end
			if (ex !== e.ex) begin $error("end_x exp %0d got %0d", e.ex, ex); errors++; end
			if (ey !== e.ey) begin $error("end_y exp %0d got %0d", e.ey, ey); errors++; end
			if (last !== e.last) begin
				$error("last_segment exp %0d got %0d", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [9:0] cell_column = '0;
	logic [9:0] cell_row = '0;
	logic signed [15:0] corner_a = '0;
	logic signed [15:0] corner_b = '0;
	logic signed [15:0] corner_c = '0;
	logic signed [15:0] corner_d = '0;
	logic signed [15:0] level = '0;
	logic result_strobe;
	logic [18:0] start_x;
	logic [18:0] start_y;
	logic [18:0] end_x;
	logic [18:0] end_y;
	logic last_segment;

	segment_scoreboard sb;
	longint cycle_count = 0;
	int gap_pct = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	contour_cell_segments_core #(
		.GRID_WIDTH(GRID_W), .GRID_HEIGHT(GRID_H), .FRACTION_BITS(FRAC)
	) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cell_column(cell_column), .cell_row(cell_row),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.corner_d(corner_d), .level(level),
		.result_strobe(result_strobe), .start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y), .last_segment(last_segment)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		if (arst_n && result_strobe)
			sb.check_segment(start_x, start_y, end_x, end_y, last_segment);
	end

	// one transaction; inputs move on the falling edge only
	task automatic send_cell(logic [9:0] ci, logic [9:0] rj, logic signed [15:0] ca,
			logic signed [15:0] cb, logic signed [15:0] cc, logic signed [15:0] cd,
			logic signed [15:0] lv);
		bit done;
		while ($urandom_range(99) < gap_pct) begin
			start <= 0;
			@(negedge clk);
		end
		cell_column <= ci;
		cell_row <= rj;
		corner_a <= ca;
		corner_b <= cb;
		corner_c <= cc;
		corner_d <= cd;
		level <= lv;
		start <= 1;
		done = 0;
		while (!done) begin
			@(posedge clk);
			if (!busy) begin
				done = 1;
				sb.note_cell(ci, rj, ca, cb, cc, cd, lv);
			end
			@(negedge clk);
		end
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	function automatic logic signed [15:0] near(logic signed [15:0] lv, int spread);
		int v;
		v = int'(lv) + $urandom_range(2 * spread) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	task automatic random_cell();
		logic [9:0] ci;
		logic [9:0] rj;
		logic signed [15:0] lv;
		int spread;
		int mode;
		ci = ($urandom_range(9) == 0) ? 10'($urandom_range(1023, 1020)) : 10'($urandom);
		rj = ($urandom_range(9) == 0) ? 10'($urandom_range(1023, 1020)) : 10'($urandom);
		lv = 16'($urandom);
		mode = $urandom_range(9);
		spread = (mode < 3) ? 3 : (mode < 7) ? 2000 : 32767;
		if (mode == 9)
			send_cell(ci, rj, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), lv);
		else
			send_cell(ci, rj, near(lv, spread), near(lv, spread), near(lv, spread),
				near(lv, spread), lv);
	endtask

	initial begin
		sb = new();
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, saddles, touching corners, out of range, clamped indices
		send_cell(0, 0, 100, -100, 100, -100, 0);
		send_cell(1023, 1023, -32768, 32767, -32768, 32767, 0);
		send_cell(1022, 5, 32767, 32767, -32768, -32768, -32768);
		send_cell(5, 1022, 32767, 32767, 32767, 32767, 32767);
		send_cell(7, 7, 10, 20, 30, 40, 5);
		send_cell(7, 7, 10, 20, 30, 40, 50);
		send_cell(3, 4, 0, 0, 0, 0, 0);
		send_cell(3, 4, 5, 0, 0, 5, 0);
		send_cell(3, 4, 0, 5, 0, -5, 0);
		send_cell(3, 4, -5, 0, 5, 0, 0);
		send_cell(9, 9, 0, 10, 10, 10, 0);
		send_cell(9, 9, 0, -10, -10, -10, 0);
		send_cell(9, 9, 1, -1, 1, -1, 0);
		send_cell(9, 9, 3, -1, -1, -1, 0);
		send_cell(9, 9, 1, 1, 1, -3, 0);
		send_cell(512, 300, -32768, -32768, -32768, 32767, 0);
		send_cell(1023, 0, 32767, -32768, 0, 0, 0);
		send_cell(682, 341, 21845, -10923, 5461, -21846, 1);
		send_cell(0, 1023, -32768, -32768, -32768, -32768, 32767);
		send_cell(100, 200, 5, 5, -5, 5, 5);
		drain();

		gap_pct = 37;
		for (int n = 0; n < N_RANDOM / 3; n++)
			random_cell();
		drain();
		gap_pct = 81;
		for (int n = 0; n < N_RANDOM / 3; n++)
			random_cell();
		gap_pct = 0;
		for (int n = 0; n < N_RANDOM - 2 * (N_RANDOM / 3); n++)
			random_cell();
		drain();

		$display("Covered %0d cells and %0d segments: saddles, touching corners,",
			sb.cells, sb.segments);
		$display("out-of-range levels, clamped indices and full-scale samples.");
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

### files.f
rtl/ccs_pkg.sv
rtl/ccs_div.sv
rtl/contour_cell_segments_core.sv
rtl/ccs_checker.sv
tb/sv/tb_top.sv
